// File: sv/gcps_pkg.sv
// Package for the game controller port serializer.
// Holds the request kinds, configuration register indexes, field widths and bit masks.
`timescale 1ns / 1ps

package gcps_pkg;

    // Request kind carried in the low bits of the slave-side tuser
    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_STROBE = 2'd1,
        MODE_UPDATE = 2'd2
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] CFG_FOUR_SCORE_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_ARCADE_MODE           = 2'd1;
    localparam logic [1:0] CFG_EXPANSION_FOUR_PLAYER = 2'd2;
    localparam logic [1:0] CFG_DIP_SWITCHES          = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int BYTE_W  = 8;
    localparam int PAD_W   = 16;
    localparam int COUNT_W = 5;
    localparam int EXP_W   = 4;
    localparam int IN_DATA_W = 56;
    localparam int IN_USER_W = 3;

    // Read count at which the four-player adapter signature appears (port 0; port 1 is one less)
    localparam logic [COUNT_W-1:0] SIG_COUNT   = 5'd19;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [COUNT_W-1:0] BASIC_COUNT = 5'd8;

    localparam logic [BYTE_W-1:0] OPEN_BUS_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] DIP_P1_MASK   = 8'hFC;
    localparam logic [PAD_W-1:0]  KEEP_MASK     = 16'h000C;
    localparam logic [PAD_W-1:0]  SWAP_MASK     = 16'h00F3;

endpackage

// File: sv/game_controller_port_serializer_unit.sv
// Game controller port serializer: two serial pad ports, four-player adapter, arcade layout.
// A read request's byte appears on the master side in the cycle after acceptance.
// Throughput: one request per cycle unless stalled; each request updates the counters, pad words
// and coin timer in the cycle it is accepted, and a one-entry output register holds the byte.
// Reset (i_rst_n low, synchronous) clears pad words, counters, strobe and coin timer and
// loads the configuration defaults (adapter signature on, arcade and expansion off, DIP 0).
`timescale 1ns / 1ps

module game_controller_port_serializer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [gcps_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gcps_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: write_value[7:0], open_bus[15:8], pads_port_zero[31:16],
    //        pads_port_one[47:32], coin_frames[55:48]
    input  logic [gcps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: mode[1:0], port[2]
    input  logic [gcps_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // read data stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: read_data[7:0]
    output logic [gcps_pkg::BYTE_W-1:0]        m_axis_tdata
);

    // configuration
    logic                                r_four_score;
    logic                                r_arcade;
    logic                                r_exp_four;
    logic [gcps_pkg::BYTE_W-1:0]         r_dip;

    // block state
    logic [gcps_pkg::PAD_W-1:0]          r_pad_word [2];
    logic [gcps_pkg::COUNT_W-1:0]        r_read_count [2];
    logic [gcps_pkg::EXP_W-1:0]          r_exp_count [2];
    logic                                r_last_strobe;
    logic [gcps_pkg::BYTE_W-1:0]         r_coin_timer;

    logic [gcps_pkg::PAD_W-1:0]          n_pad_word [2];
    logic [gcps_pkg::COUNT_W-1:0]        n_read_count [2];
    logic [gcps_pkg::EXP_W-1:0]          n_exp_count [2];
    logic                                n_last_strobe;
    logic [gcps_pkg::BYTE_W-1:0]         n_coin_timer;

    // output register
    logic                                r_out_valid;
    logic [gcps_pkg::BYTE_W-1:0]         r_out_data;
    logic                                n_out_valid;
    logic [gcps_pkg::BYTE_W-1:0]         n_out_data;

    // request fields
    gcps_pkg::t_mode                     req_mode;
    logic                                req_port;
    logic [gcps_pkg::BYTE_W-1:0]         req_write_value;
    logic [gcps_pkg::BYTE_W-1:0]         req_open_bus;
    logic [gcps_pkg::PAD_W-1:0]          req_pads_zero;
    logic [gcps_pkg::PAD_W-1:0]          req_pads_one;
    logic [gcps_pkg::BYTE_W-1:0]         req_coin_frames;
    logic                                req_take;

    // read datapath
    logic [gcps_pkg::PAD_W-1:0]          sel_pad;
    logic [gcps_pkg::COUNT_W-1:0]        sel_count;
    logic [gcps_pkg::EXP_W-1:0]          sel_exp;
    logic                                pad_bit;
    logic                                exp_bit;
    logic [gcps_pkg::COUNT_W-1:0]        sig_count;
    logic [gcps_pkg::BYTE_W-1:0]         rd_byte;
    logic [gcps_pkg::BYTE_W-1:0]         coin_load;

    assign req_mode        = gcps_pkg::t_mode'(s_axis_tuser[1:0]);
    assign req_port        = s_axis_tuser[2];
    assign req_write_value = s_axis_tdata[7:0];
    assign req_open_bus    = s_axis_tdata[15:8];
    assign req_pads_zero   = s_axis_tdata[31:16];
    assign req_pads_one    = s_axis_tdata[47:32];
    assign req_coin_frames = s_axis_tdata[55:48];

    // Take a new request whenever the output slot is empty or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign req_take      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Selected port's state
    assign sel_pad   = r_pad_word[req_port];
    assign sel_count = r_read_count[req_port];
    assign sel_exp   = r_exp_count[req_port];

    // Pad bit at the read position; zero once the count runs past the word
    assign pad_bit = (sel_count[4] == 1'b0) ? sel_pad[sel_count[3:0]] : 1'b0;
    // Expansion pad bit comes from the high byte; reads as one after eight shifts
    assign exp_bit = sel_exp[3] ? 1'b1 : sel_pad[{1'b1, sel_exp[2:0]}];
    assign sig_count = gcps_pkg::SIG_COUNT - {{(gcps_pkg::COUNT_W-1){1'b0}}, req_port};

    always_comb begin
        rd_byte = '0;
        if (r_arcade) begin
            rd_byte[0] = (sel_count >= gcps_pkg::BASIC_COUNT) ? 1'b1 : pad_bit;
            if (req_port == 1'b0) begin
                rd_byte[4:3] = r_dip[1:0];
                rd_byte[2]   = (r_coin_timer != '0);
            end else begin
                rd_byte = rd_byte | (r_dip & gcps_pkg::DIP_P1_MASK);
            end
        end else begin
            if (r_four_score) begin
                rd_byte[0] = pad_bit | (sel_count == sig_count);
            end else begin
                rd_byte[0] = pad_bit | (sel_count >= gcps_pkg::BASIC_COUNT);
            end
            if (r_exp_four) begin
                rd_byte[1] = exp_bit;
            end
            rd_byte = rd_byte | (req_open_bus & gcps_pkg::OPEN_BUS_MASK);
        end
    end

    // Coin timer after an optional reload
    assign coin_load = (req_coin_frames != '0) ? req_coin_frames : r_coin_timer;

    // Next-state logic for one accepted request
    always_comb begin
        n_pad_word    = r_pad_word;
        n_read_count  = r_read_count;
        n_exp_count   = r_exp_count;
        n_last_strobe = r_last_strobe;
        n_coin_timer  = r_coin_timer;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;

        if (req_take) begin
            case (req_mode)
                gcps_pkg::MODE_READ: begin
                    n_out_valid = 1'b1;
                    n_out_data  = rd_byte;
                    if (r_arcade) begin
                        // advance only while the eight buttons are shifting out
                        if (sel_count < gcps_pkg::BASIC_COUNT) begin
                            n_read_count[req_port] = sel_count + 1'b1;
                        end
                    end else begin
                        if (sel_count != gcps_pkg::COUNT_MAX) begin
                            n_read_count[req_port] = sel_count + 1'b1;
                        end
                        if (r_exp_four && !sel_exp[3]) begin
                            n_exp_count[req_port] = sel_exp + 1'b1;
                        end
                    end
                end
                gcps_pkg::MODE_STROBE: begin
                    // falling strobe restarts the shift on both ports
                    if (r_last_strobe && !req_write_value[0]) begin
                        n_read_count[0] = '0;
                        n_read_count[1] = '0;
                        if (r_exp_four) begin
                            n_exp_count[0] = '0;
                            n_exp_count[1] = '0;
                        end
                    end
                    n_last_strobe = req_write_value[0];
                end
                gcps_pkg::MODE_UPDATE: begin
                    n_coin_timer = coin_load;
                    if (r_arcade) begin
                        // each port keeps bits 3:2 and takes the other port's remaining buttons
                        n_pad_word[0] = (req_pads_zero & gcps_pkg::KEEP_MASK)
                                      | (req_pads_one  & gcps_pkg::SWAP_MASK);
                        n_pad_word[1] = (req_pads_one  & gcps_pkg::KEEP_MASK)
                                      | (req_pads_zero & gcps_pkg::SWAP_MASK);
                        if (coin_load != '0) begin
                            n_coin_timer = coin_load - 1'b1;
                        end
                    end else begin
                        n_pad_word[0] = req_pads_zero;
                        n_pad_word[1] = req_pads_one;
                    end
                end
                default: begin
                    // unused kind: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_score    <= 1'b1;
            r_arcade        <= 1'b0;
            r_exp_four      <= 1'b0;
            r_dip           <= '0;
            r_pad_word[0]   <= '0;
            r_pad_word[1]   <= '0;
            r_read_count[0] <= '0;
            r_read_count[1] <= '0;
            r_exp_count[0]  <= '0;
            r_exp_count[1]  <= '0;
            r_last_strobe   <= 1'b0;
            r_coin_timer    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    gcps_pkg::CFG_FOUR_SCORE_ENABLE:     r_four_score <= i_cfg_wdata[0];
                    gcps_pkg::CFG_ARCADE_MODE:           r_arcade     <= i_cfg_wdata[0];
                    gcps_pkg::CFG_EXPANSION_FOUR_PLAYER: r_exp_four   <= i_cfg_wdata[0];
                    gcps_pkg::CFG_DIP_SWITCHES:          r_dip        <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_pad_word    <= n_pad_word;
            r_read_count  <= n_read_count;
            r_exp_count   <= n_exp_count;
            r_last_strobe <= n_last_strobe;
            r_coin_timer  <= n_coin_timer;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

// File: test/tb_top.sv
// Self-checking bench for game_controller_port_serializer_unit: directed table, then random phases.
// Depends on gcps_pkg for request kinds, register indexes, widths and masks.
`timescale 1ns / 1ps

module tb_top;

    // Mode 3 is not a request kind; the block must ignore it
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned PHASE_ITEMS = 60;

    // One request as it travels on the slave side
    typedef struct packed {
        logic [1:0]                  kind;
        logic                        port;
        logic [gcps_pkg::BYTE_W-1:0] write_value;
        logic [gcps_pkg::BYTE_W-1:0] open_bus;
        logic [gcps_pkg::PAD_W-1:0]  pads_zero;
        logic [gcps_pkg::PAD_W-1:0]  pads_one;
        logic [gcps_pkg::BYTE_W-1:0] coins;
    } t_req;

    // Directed row: the request and, where obvious, the byte it must return
    typedef struct packed {
        t_req                        req;
        logic                        known;
        logic [gcps_pkg::BYTE_W-1:0] want;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_wr_en = 1'b0;
    logic [gcps_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [gcps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // tdata: write_value, open_bus, pads_port_zero, pads_port_one, coin_frames (low bit up)
    logic [gcps_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    // tuser: mode, port (low bit up)
    logic [gcps_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    // tdata: read_data
    logic [gcps_pkg::BYTE_W-1:0]      m_axis_tdata;

    game_controller_port_serializer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Model copy of the configuration (reset defaults)
    logic                        cfg_four_score = 1'b1;
    logic                        cfg_arcade     = 1'b0;
    logic                        cfg_expansion  = 1'b0;
    logic [gcps_pkg::BYTE_W-1:0] cfg_dip        = '0;

    // Model copy of the port state
    logic [gcps_pkg::PAD_W-1:0]   pad_latch [2] = '{default: '0};
    logic [gcps_pkg::COUNT_W-1:0] bit_pos   [2] = '{default: '0};
    logic [gcps_pkg::EXP_W-1:0]   exp_pos   [2] = '{default: '0};
    logic                         strobe_q  = 1'b0;
    logic [gcps_pkg::BYTE_W-1:0]  coin_left = '0;

    // Bytes that port reads must still return, oldest first
    logic [gcps_pkg::BYTE_W-1:0] read_bytes_due [$];
    int unsigned                 mismatch_count = 0;
    // When set, neither side inserts gaps
    logic                        quiet = 1'b0;

    function automatic t_req mk(input logic [1:0] kind, input logic port,
                                input logic [7:0] wv, input logic [7:0] bus,
                                input logic [15:0] p0, input logic [15:0] p1,
                                input logic [7:0] coins);
        t_req r;
        r.kind        = kind;
        r.port        = port;
        r.write_value = wv;
        r.open_bus    = bus;
        r.pads_zero   = p0;
        r.pads_one    = p1;
        r.coins       = coins;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet) return 0;
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the model by one accepted request; a port read produces one byte
    task automatic predict_port_byte(input t_req r, output logic produced,
                                     output logic [gcps_pkg::BYTE_W-1:0] rd_byte);
        logic [gcps_pkg::COUNT_W-1:0] c;
        logic [gcps_pkg::EXP_W-1:0]   e;
        logic [gcps_pkg::COUNT_W-1:0] epos;
        logic [gcps_pkg::BYTE_W-1:0]  d;
        int                           p;
        produced = 1'b0;
        rd_byte  = '0;
        p = r.port;
        if (r.kind == gcps_pkg::MODE_READ) begin
            produced = 1'b1;
            c = bit_pos[p];
            d = '0;
            if (cfg_arcade) begin
                // Arcade layout: bit 0 stops advancing after eight reads
                if (c >= gcps_pkg::BASIC_COUNT) begin
                    d[0] = 1'b1;
                end else begin
                    d[0] = (c < gcps_pkg::PAD_W) ? pad_latch[p][c[3:0]] : 1'b0;
                    bit_pos[p] = c + 1'b1;
                end
                if (p == 0) begin
                    d[4:3] = cfg_dip[1:0];
                    if (coin_left != 0) d[2] = 1'b1;
                end else begin
                    d = d | (cfg_dip & gcps_pkg::DIP_P1_MASK);
                end
            end else begin
                d[0] = (c < gcps_pkg::PAD_W) ? pad_latch[p][c[3:0]] : 1'b0;
                if (!cfg_four_score) begin
                    if (c >= gcps_pkg::BASIC_COUNT) d[0] = 1'b1;
                end else if (c == gcps_pkg::SIG_COUNT - gcps_pkg::COUNT_W'(p)) begin
                    // adapter signature bit
                    d[0] = 1'b1;
                end
                if (c < gcps_pkg::COUNT_MAX) bit_pos[p] = c + 1'b1;
                if (cfg_expansion) begin
                    e    = exp_pos[p];
                    epos = {1'b0, e} + 5'd8;
                    d[1] = (epos < gcps_pkg::PAD_W) ? pad_latch[p][epos[3:0]] : 1'b0;
                    if (e >= 8) d[1] = 1'b1;
                    else exp_pos[p] = e + 1'b1;
                end
                d = d | (r.open_bus & gcps_pkg::OPEN_BUS_MASK);
            end
            rd_byte = d;
        end else if (r.kind == gcps_pkg::MODE_STROBE) begin
            // Falling strobe restarts the serial streams
            if (strobe_q && !r.write_value[0]) begin
                bit_pos[0] = '0;
                bit_pos[1] = '0;
                if (cfg_expansion) begin
                    exp_pos[0] = '0;
                    exp_pos[1] = '0;
                end
            end
            strobe_q = r.write_value[0];
        end else if (r.kind == gcps_pkg::MODE_UPDATE) begin
            if (r.coins != 0) coin_left = r.coins;
            pad_latch[0] = r.pads_zero;
            pad_latch[1] = r.pads_one;
            if (cfg_arcade) begin
                // Cross the button bits between the ports, drop the high bytes
                pad_latch[0] = (r.pads_zero & gcps_pkg::KEEP_MASK)
                             | (r.pads_one & gcps_pkg::SWAP_MASK);
                pad_latch[1] = (r.pads_one & gcps_pkg::KEEP_MASK)
                             | (r.pads_zero & gcps_pkg::SWAP_MASK);
                if (coin_left != 0) coin_left = coin_left - 1'b1;
            end
        end
    endtask

    // Present one request after a random gap, hold it until accepted, then predict
    task automatic issue(input t_req r, input logic known,
                         input logic [gcps_pkg::BYTE_W-1:0] want);
        int unsigned                 gap;
        logic                        produced;
        logic [gcps_pkg::BYTE_W-1:0] rd_byte;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.coins, r.pads_one, r.pads_zero, r.open_bus, r.write_value};
        s_axis_tuser  <= {r.port, r.kind};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_port_byte(r, produced, rd_byte);
        if (produced) read_bytes_due.push_back(known ? want : rd_byte);
    endtask

    // Drop valid and hold until every read byte has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (read_bytes_due.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [gcps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gcps_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            gcps_pkg::CFG_FOUR_SCORE_ENABLE:     cfg_four_score = val[0];
            gcps_pkg::CFG_ARCADE_MODE:           cfg_arcade     = val[0];
            gcps_pkg::CFG_EXPANSION_FOUR_PLAYER: cfg_expansion  = val[0];
            gcps_pkg::CFG_DIP_SWITCHES:          cfg_dip        = val;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic fs, input logic arc, input logic expn,
                                  input logic [7:0] dip);
        put_reg(gcps_pkg::CFG_FOUR_SCORE_ENABLE, {7'b0, fs});
        put_reg(gcps_pkg::CFG_ARCADE_MODE, {7'b0, arc});
        put_reg(gcps_pkg::CFG_EXPANSION_FOUR_PLAYER, {7'b0, expn});
        put_reg(gcps_pkg::CFG_DIP_SWITCHES, dip);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Coin frame counts: often none, sometimes a short timer, else anything
    function automatic logic [7:0] pick_coins();
        int unsigned roll;
        roll = $urandom_range(0, 3);
        if (roll < 2) return 8'd0;
        if (roll == 2) return 8'($urandom_range(1, 3));
        return 8'($urandom);
    endfunction

    // Random part of one phase: mostly strobe-and-shift sequences, some noise
    task automatic random_phase(input int unsigned target);
        int unsigned sent;
        int unsigned n;
        int unsigned k;
        logic        one_port;
        logic        port_pick;
        logic [1:0]  kind;
        sent = 0;
        while (sent < target) begin
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    issue(mk(gcps_pkg::MODE_UPDATE, 1'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom), 16'($urandom), pick_coins()), 1'b0, '0);
                    sent++;
                end
                issue(mk(gcps_pkg::MODE_STROBE, 1'($urandom), {7'($urandom), 1'b1},
                         8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)),
                      1'b0, '0);
                issue(mk(gcps_pkg::MODE_STROBE, 1'($urandom), {7'($urandom), 1'b0},
                         8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)),
                      1'b0, '0);
                sent += 2;
                n         = $urandom_range(1, 40);
                one_port  = 1'($urandom);
                port_pick = 1'($urandom);
                for (k = 0; k < n; k++) begin
                    if (!one_port) port_pick = 1'($urandom);
                    // now and then a frame arrives in the middle of a shift-out
                    if ($urandom_range(0, 19) == 0) begin
                        issue(mk(gcps_pkg::MODE_UPDATE, 1'($urandom), 8'($urandom),
                                 8'($urandom), 16'($urandom), 16'($urandom), pick_coins()),
                              1'b0, '0);
                        sent++;
                    end
                    issue(mk(gcps_pkg::MODE_READ, port_pick, 8'($urandom), 8'($urandom),
                             16'($urandom), 16'($urandom), 8'($urandom)), 1'b0, '0);
                    sent++;
                end
            end else begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    kind = ($urandom_range(0, 15) == 0) ? MODE_UNUSED
                                                          : 2'($urandom_range(0, 2));
                    issue(mk(kind, 1'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom), 16'($urandom), pick_coins()), 1'b0, '0);
                    if (kind != MODE_UNUSED) sent++;
                end
            end
        end
        quiet = 1'b0;
    endtask

    // Check each returned byte against the oldest one due
    always @(posedge i_clk) begin : check_read_bytes
        logic [gcps_pkg::BYTE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (read_bytes_due.size() == 0) begin
                $display("%0t: unexpected read byte, expected none, actual %02h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = read_bytes_due.pop_front();
                if (m_axis_tdata !== want) begin
                    $display("%0t: read_data mismatch, expected %02h, actual %02h",
                             $time, want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: runs of ready broken by stalls of random length
    initial begin : sink_pacing
        int unsigned run;
        int unsigned stall;
        forever begin
            run = $urandom_range(1, 20);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Hard stop well beyond the slowest passing run
    initial begin : run_limit
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_row        script [$];
        int unsigned i;
        int unsigned drain;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings: adapter on, arcade and expansion off
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b0, 8'h00, 8'hFF, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'hC0});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b1, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF,
                              8'hFF), 1'b1, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_UPDATE, 1'b0, 8'h00, 8'h00, 16'hFFFF, 16'h0000,
                              8'hFF), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'h01, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b1, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF,
                              8'hFF), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b0, 8'h00, 8'h3F, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'h01});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b1, 8'h00, 8'hC0, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'hC0});
        script.push_back('{mk(MODE_UNUSED, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                           1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b0, 8'h00, 8'h80, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'h81});
        // low strobe without a high one before it: counters keep going
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'hFE, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b1, 8'h00, 8'h40, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'h40});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'hFF, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_UPDATE, 1'b0, 8'h00, 8'h00, 16'h0000, 16'hFFFF,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'h01});
        script.push_back('{mk(gcps_pkg::MODE_READ, 1'b0, 8'h00, 8'hFF, 16'h0000, 16'h0000,
                              8'h00), 1'b1, 8'hC0});
        script.push_back('{mk(gcps_pkg::MODE_UPDATE, 1'b0, 8'h00, 8'h00, 16'hA55A, 16'h5AA5,
                              8'h01), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'h01, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        script.push_back('{mk(gcps_pkg::MODE_STROBE, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000,
                              8'h00), 1'b0, 8'h00});
        for (i = 0; i < 6; i++) begin
            script.push_back('{mk(gcps_pkg::MODE_READ, 1'(i), 8'h00, 8'(i * 8'h45), 16'h0000,
                                  16'h0000, 8'h00), 1'b0, 8'h00});
        end
        foreach (script[j]) issue(script[j].req, script[j].known, script[j].want);

        // Random phases; each settings change waits for the block to go idle
        for (i = 0; i < 6; i++) begin
            wait_idle();
            case (i)
                0: write_settings(1'b0, 1'b0, 1'b1, 8'hFF);
                1: write_settings(1'b1, 1'b0, 1'b1, 8'h00);
                2: write_settings(1'b1, 1'b1, 1'b0, 8'hFF);
                3: write_settings(1'b0, 1'b1, 1'b1, 8'($urandom));
                4: write_settings(1'b0, 1'b0, 1'b0, 8'($urandom));
                default: write_settings(1'($urandom), 1'($urandom), 1'($urandom),
                                        8'($urandom));
            endcase
            random_phase(PHASE_ITEMS);
        end

        // Drain the read stream, then allow time for stray output
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (read_bytes_due.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (read_bytes_due.size() != 0) begin
            $display("%0t: %0d read bytes never returned, expected %02h first, actual none",
                     $time, read_bytes_due.size(), read_bytes_due[0]);
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/gcps_pkg.sv
sv/game_controller_port_serializer_unit.sv
test/tb_top.sv
